/* sv/kmd_pkg.sv */
// shared types and constants for the key matrix debouncer
package kmd_pkg;

   localparam int KEY_SLOTS = 20;
   localparam int KEY_W     = 5;
   localparam int STAMP_W   = 32;
   localparam int DEB_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   localparam logic [DEB_W-1:0]     DEBOUNCE_RESET = 16'd5;
   localparam logic [KEY_SLOTS-1:0] UNUSED_RESET   = 20'h0801C;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_MASK = 2'd1;

   localparam logic [1:0] PH_IDLE         = 2'd0;
   localparam logic [1:0] PH_CONF_PRESS   = 2'd1;
   localparam logic [1:0] PH_PRESSED      = 2'd2;
   localparam logic [1:0] PH_CONF_RELEASE = 2'd3;

   typedef struct packed {
      logic [KEY_SLOTS-1:0] raw_pressed;
      logic [STAMP_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [KEY_SLOTS-1:0] stable_keys;
      logic [KEY_SLOTS-1:0] press_events;
      logic [KEY_SLOTS-1:0] release_events;
      logic [KEY_SLOTS-1:0] changed_keys;
   } rsp_type;

   // decision for one key, from the shared unit back to the sequencer
   typedef struct packed {
      logic [1:0] next_phase;
      logic       load_stamp;
      logic       press;
      logic       release_key;
   } key_step_type;

endpackage

/* sv/key_matrix_debounce.sv */
// key matrix debouncer top level: scan sequencer, key state and result register
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data  (raw_pressed, now_ms)
//   rsp      out        rsp_valid/rsp_stall  rsp_data  (stable, press, release, changed)
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// a scan works through min(ROWS*COLS, 20) matrix positions from acceptance to result: one
// matrix position per cycle through the single elapsed-time compare unit, then the load
// of the result register; the next scan can be taken only once the result is loaded, so
// a new scan is never taken before the last one is through. req_stall is high from acceptance
// until the result is loaded, and the load waits while an earlier result is stalled;
// a stalled result is held while the next scan is taken and run.
// synchronous reset sets every key idle, clears the stable bitmap and loads the
// register defaults.
module key_matrix_debounce
   import kmd_pkg::*;
#(
   parameter int ROWS = 5,
   parameter int COLS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int MATRIX   = ROWS * COLS;
   localparam int SCAN_LEN = (MATRIX < KEY_SLOTS) ? MATRIX : KEY_SLOTS;
   localparam logic [KEY_W-1:0] LAST_POS = KEY_W'(SCAN_LEN - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic [KEY_W-1:0]     pos_ff, pos_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [DEB_W-1:0]     debounce_ff;
   logic [KEY_SLOTS-1:0] unused_ff;
   logic [KEY_SLOTS-1:0] raw_ff;
   logic [STAMP_W-1:0]   now_ff;
   logic [KEY_SLOTS-1:0] stable_ff;
   logic [KEY_SLOTS-1:0] press_ff;
   logic [KEY_SLOTS-1:0] release_ff;
   logic [1:0]           phase_ff [KEY_SLOTS];
   logic [STAMP_W-1:0]   stamp_ff [KEY_SLOTS];
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic         req_take;
   logic         active;
   logic         out_free;
   key_step_type step;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // a position is worked only when it is in use
   assign active = (state_ff == ST_SCAN) && !unused_ff[pos_ff];

   kmd_key_unit u_key_unit (
      .phase       (phase_ff[key_ff]),
      .down        (raw_ff[pos_ff]),
      .stamp       (stamp_ff[key_ff]),
      .now_ms      (now_ff),
      .debounce_ms (debounce_ff),
      .step        (step)
   );

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
               pos_in   = '0;
               key_in   = '0;
            end
         end
         ST_SCAN: begin
            pos_in = pos_ff + KEY_W'(1);
            if (active) key_in = key_ff + KEY_W'(1);
            if (pos_ff == LAST_POS) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= '0;
         key_ff      <= '0;
         debounce_ff <= DEBOUNCE_RESET;
         unused_ff   <= UNUSED_RESET;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         key_ff   <= key_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DEBOUNCE_MS: debounce_ff <= csr_wdata[DEB_W-1:0];
               CSR_UNUSED_MASK: unused_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // scan transaction latch and per-scan event accumulators
   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff     <= req_data.raw_pressed;
         now_ff     <= req_data.now_ms;
         press_ff   <= '0;
         release_ff <= '0;
      end else if (active) begin
         if (step.press)       press_ff[key_ff]   <= 1'b1;
         if (step.release_key) release_ff[key_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= '0;
         for (int k = 0; k < KEY_SLOTS; k++) phase_ff[k] <= PH_IDLE;
      end else if (active) begin
         phase_ff[key_ff] <= step.next_phase;
         if (step.press)       stable_ff[key_ff] <= 1'b1;
         if (step.release_key) stable_ff[key_ff] <= 1'b0;
      end
   end

   // stamps are used only in a confirming phase, after the step that entered it has written them
   always_ff @(posedge clock) begin
      if (active && step.load_stamp) stamp_ff[key_ff] <= now_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FLUSH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FLUSH && out_free) begin
         rsp_data_ff.stable_keys    <= stable_ff;
         rsp_data_ff.press_events   <= press_ff;
         rsp_data_ff.release_events <= release_ff;
         rsp_data_ff.changed_keys   <= press_ff | release_ff;
      end
   end

   // a new result only follows the flush step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FLUSH))
      else $error("result raised without a finished scan");

   // a key cannot be confirmed pressed and released in the same scan
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.press_events & rsp_data.release_events) == '0))
      else $error("press and release events overlap");

   // confirmed presses show up as stable, confirmed releases as not stable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.press_events & ~rsp_data.stable_keys) == '0) &&
                    ((rsp_data.release_events & rsp_data.stable_keys) == '0))
      else $error("events disagree with stable bitmap");

   // the key counter never runs ahead of the position counter
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (key_ff <= pos_ff))
      else $error("dense key index ahead of matrix position");

endmodule

/* sv/kmd_key_unit.sv */
// shared per-key unit: elapsed-time compare and debounce phase decision
module kmd_key_unit
   import kmd_pkg::*;
(
   input  logic [1:0]         phase,
   input  logic               down,
   input  logic [STAMP_W-1:0] stamp,
   input  logic [STAMP_W-1:0] now_ms,
   input  logic [DEB_W-1:0]   debounce_ms,
   output key_step_type       step
);

   logic [STAMP_W-1:0] elapsed;
   logic               wait_done;

   assign elapsed = now_ms - stamp;
   // negative signed elapsed means the wait is still running
   assign wait_done = !elapsed[STAMP_W-1] &&
                      (elapsed >= {{(STAMP_W-DEB_W){1'b0}}, debounce_ms});

   always_comb begin
      step.next_phase  = phase;
      step.load_stamp  = 1'b0;
      step.press       = 1'b0;
      step.release_key = 1'b0;
      unique case (phase)
         PH_IDLE: begin
            if (down) begin
               step.next_phase = PH_CONF_PRESS;
               step.load_stamp = 1'b1;
            end
         end
         PH_CONF_PRESS: begin
            if (wait_done) begin
               if (down) begin
                  step.next_phase = PH_PRESSED;
                  step.press      = 1'b1;
               end else begin
                  step.next_phase = PH_IDLE;
               end
            end
         end
         PH_PRESSED: begin
            if (!down) begin
               step.next_phase = PH_CONF_RELEASE;
               step.load_stamp = 1'b1;
            end
         end
         default: begin
            if (wait_done) begin
               if (!down) begin
                  step.next_phase  = PH_IDLE;
                  step.release_key = 1'b1;
               end else begin
                  step.next_phase = PH_PRESSED;
               end
            end
         end
      endcase
   end

endmodule
